// ===== rtl/core/ps2mt_pkg.sv =====
package ps2mt_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DELTA_W = BYTE_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COORD_W-1:0] RESET_WIDTH  = 16'd1024;
  localparam logic [COORD_W-1:0] RESET_HEIGHT = 16'd768;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  // header byte bit positions
  localparam int unsigned HDR_BTN_LEFT   = 0;
  localparam int unsigned HDR_BTN_RIGHT  = 1;
  localparam int unsigned HDR_BTN_MIDDLE = 2;
  localparam int unsigned HDR_SYNC       = 3;
  localparam int unsigned HDR_X_SIGN     = 4;
  localparam int unsigned HDR_Y_SIGN     = 5;

  typedef enum logic [2:0] {
    POS_HDR = 3'b001,
    POS_X   = 3'b010,
    POS_Y   = 3'b100
  } byte_pos_t;

endpackage

// ===== rtl/core/ps2mt_axis_step.sv =====
module ps2mt_axis_step (
  input  logic [ps2mt_pkg::COORD_W-1:0]        pos_i,
  input  logic signed [ps2mt_pkg::DELTA_W-1:0] delta_i,
  input  logic                                 subtract_i,
  input  logic [ps2mt_pkg::COORD_W-1:0]        res_i,
  output logic [ps2mt_pkg::COORD_W-1:0]        next_o
);
  import ps2mt_pkg::*;

  localparam int unsigned SUM_W = COORD_W + 2;

  logic signed [SUM_W-1:0] delta_ext;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    delta_ext = SUM_W'(delta_i);
    if (subtract_i) begin
      sum = $signed({2'b00, pos_i}) - delta_ext;
    end else begin
      sum = $signed({2'b00, pos_i}) + delta_ext;
    end
  end

  always_comb begin
    priority if (sum[SUM_W-1]) begin
      next_o = '0;
    end else if (res_i == '0) begin
      next_o = '0;
    end else if (sum[SUM_W-2:0] >= {1'b0, res_i}) begin
      next_o = res_i - 1'b1;
    end else begin
      next_o = sum[COORD_W-1:0];
    end
  end

endmodule

// ===== rtl/core/ps2_mouse_packet_cursor_tracker.sv =====
// A packet's third byte reaches out_* via the byte register, then the result register.
// Throughput: one byte per cycle; the byte register and the result register
// advance together, so a waiting result stalls only the third byte of the next packet.
// Reset (rst_n low, synchronous): cursor at 0,0, packet assembly back to the
// header byte, screen size 1024 x 768, both pipeline registers empty.
module ps2_mouse_packet_cursor_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ps2mt_pkg::BYTE_W-1:0]      in_data_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ps2mt_pkg::COORD_W-1:0]     out_cursor_x,
  output logic [ps2mt_pkg::COORD_W-1:0]     out_cursor_y,
  output logic                              out_button_left,
  output logic                              out_button_right,
  output logic                              out_button_middle,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ps2mt_pkg::COORD_W-1:0]     cfg_data
);
  import ps2mt_pkg::*;

  logic                 in_vld_r, in_vld_nxt;
  logic [BYTE_W-1:0]    in_byte_r;
  byte_pos_t            pos_r, pos_nxt;
  logic [BYTE_W-1:0]    hdr_r, hdr_nxt;
  logic [BYTE_W-1:0]    xdat_r, xdat_nxt;
  logic [COORD_W-1:0]   px_r, px_nxt;
  logic [COORD_W-1:0]   py_r, py_nxt;
  logic [COORD_W-1:0]   width_r, height_r;
  logic                 out_vld_r, out_vld_nxt;
  logic [COORD_W-1:0]   out_x_r, out_y_r;
  logic [2:0]           out_btn_r;

  logic                 in_acc;
  logic                 emits;
  logic                 fire;
  logic                 done;
  logic [COORD_W-1:0]   px_new, py_new;

  assign emits    = (pos_r == POS_Y);
  assign fire     = in_vld_r && (!emits || !out_vld_r || !out_stall);
  assign done     = fire && emits;
  assign in_stall = in_vld_r && !fire;
  assign in_acc   = in_valid && !in_stall;

  ps2mt_axis_step u_step_x (
    .pos_i      (px_r),
    .delta_i    ($signed({hdr_r[HDR_X_SIGN], xdat_r})),
    .subtract_i (1'b0),
    .res_i      (width_r),
    .next_o     (px_new)
  );

  ps2mt_axis_step u_step_y (
    .pos_i      (py_r),
    .delta_i    ($signed({hdr_r[HDR_Y_SIGN], in_byte_r})),
    .subtract_i (1'b1),
    .res_i      (height_r),
    .next_o     (py_new)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    hdr_nxt  = hdr_r;
    xdat_nxt = xdat_r;
    px_nxt   = px_r;
    py_nxt   = py_r;
    if (fire) begin
      unique case (pos_r)
        POS_HDR: begin
          if (in_byte_r[HDR_SYNC]) begin
            hdr_nxt = in_byte_r;
            pos_nxt = POS_X;
          end
        end
        POS_X: begin
          xdat_nxt = in_byte_r;
          pos_nxt  = POS_Y;
        end
        POS_Y: begin
          px_nxt  = px_new;
          py_nxt  = py_new;
          pos_nxt = POS_HDR;
        end
        default: begin
          pos_nxt = POS_HDR;
        end
      endcase
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (done) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      pos_r     <= POS_HDR;
      hdr_r     <= '0;
      xdat_r    <= '0;
      px_r      <= '0;
      py_r      <= '0;
      width_r   <= RESET_WIDTH;
      height_r  <= RESET_HEIGHT;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      pos_r     <= pos_nxt;
      hdr_r     <= hdr_nxt;
      xdat_r    <= xdat_nxt;
      px_r      <= px_nxt;
      py_r      <= py_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SCREEN_WIDTH) begin
          width_r <= cfg_data;
        end else if (cfg_index == CFG_SCREEN_HEIGHT) begin
          height_r <= cfg_data;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_data_byte;
    end
    if (done) begin
      out_x_r   <= px_new;
      out_y_r   <= py_new;
      out_btn_r <= {hdr_r[HDR_BTN_MIDDLE], hdr_r[HDR_BTN_RIGHT], hdr_r[HDR_BTN_LEFT]};
    end
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_vld_r;
  assign out_cursor_x      = out_x_r;
  assign out_cursor_y      = out_y_r;
  assign out_button_left   = out_btn_r[0];
  assign out_button_right  = out_btn_r[1];
  assign out_button_middle = out_btn_r[2];

endmodule

// ===== rtl/core/ps2mt_checker.sv =====
module ps2mt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [ps2mt_pkg::COORD_W-1:0]     out_cursor_x,
  input logic [ps2mt_pkg::COORD_W-1:0]     out_cursor_y,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [ps2mt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [ps2mt_pkg::COORD_W-1:0]     cfg_data
);
  import ps2mt_pkg::*;

  logic [COORD_W-1:0] width_r, height_r;

  // shadow of the screen size as seen on the config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SCREEN_WIDTH) begin
        width_r <= cfg_data;
      end else if (cfg_index == CFG_SCREEN_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_x == '0 || out_cursor_x < width_r))
    else $error("cursor x outside screen");

  a_y_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_y == '0 || out_cursor_y < height_r))
    else $error("cursor y outside screen");

  a_no_stall_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor_x) && $stable(out_cursor_y))
    else $error("stalled result word changed");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config port not ready");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mt_checker u_ps2mt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_cursor_x (out_cursor_x),
  .out_cursor_y (out_cursor_y),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data)
);
